[hdl/fdd_pkg.sv]
// ----------------------------------------------------------------------------
// fdd_pkg
// shared types and constants for the floppy disk dma controller
// ----------------------------------------------------------------------------
`default_nettype none
package fdd_pkg;

    localparam int FifoDepthDef = 6;
    localparam int WatchdogLimitDef = 160000;
    localparam logic [15:0] SyncWordRst = 16'h4489;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        CMD_DISK  = 2'd0,
        CMD_DMA   = 2'd1,
        CMD_START = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_WAIT  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_WRITE = 2'd3
    } mode_t;

    localparam logic [0:0] ADDR_SYNC = 1'b0;
    localparam logic [0:0] ADDR_AUTO = 1'b1;

    // one classified item as handed from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] data;
        logic [13:0] word_count;
        logic        write_dir;
        logic        wait_for_sync;
    } item_t;

    // one result item
    typedef struct packed {
        logic        last;
        logic [2:0]  fifo_fill;
        logic [1:0]  dma_mode;
        logic        block_irq;
        logic        sync_irq;
        logic [7:0]  disk_byte;
        logic        disk_byte_valid;
        logic        word_taken;
        logic [15:0] mem_word;
        logic        mem_write_valid;
    } result_t;

endpackage
`default_nettype wire

[hdl/floppy_disk_dma_controller.sv]
// an accepted item is held in the front queue, and its result in the result register
// throughput: one item per cycle unless the output stalls; after a final
//   write word the fifo drains a byte per result, taking no new item
// reset: rst_n asynchronous, clears state, fifo, mode off, sync word 0x4489
// ----------------------------------------------------------------------------
// floppy_disk_dma_controller
// floppy controller with sync detect, byte fifo and word dma
// ----------------------------------------------------------------------------
`default_nettype none
module floppy_disk_dma_controller
#(
    parameter int FIFO_DEPTH     = fdd_pkg::FifoDepthDef,
    parameter int WATCHDOG_LIMIT = fdd_pkg::WatchdogLimitDef
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd[1:0], data[17:2], word_count[31:18], write_dir[32], wait_for_sync[33]
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // mem_write_valid[0], mem_word[16:1], word_taken[17], disk_byte_valid[18],
    // disk_byte[26:19], sync_irq[27], block_irq[28], dma_mode[30:29],
    // fifo_fill[33:31]
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fdd_pkg::*;

    logic [15:0] sync_reg;
    logic        auto_reg;
    logic        q_valid, q_take;
    item_t       q_item;
    result_t     res;

    assign pready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SyncWordRst;
            auto_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == ADDR_SYNC) sync_reg <= pwdata[15:0];
            else auto_reg <= pwdata[0];
        end
    end

    // register reads
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == ADDR_AUTO) prdata = {31'd0, auto_reg};
            else prdata = {16'd0, sync_reg};
        end
    end

    fdd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_bits  (s_axis_tdata[33:0]),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_item   (q_item)
    );

    fdd_back #(.FIFO_DEPTH(FIFO_DEPTH), .WATCHDOG_LIMIT(WATCHDOG_LIMIT)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sync_word (sync_reg),
        .auto_sync (auto_reg),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {6'd0, res.fifo_fill, res.dma_mode, res.block_irq, res.sync_irq,
                           res.disk_byte, res.disk_byte_valid, res.word_taken,
                           res.mem_word, res.mem_write_valid};
    assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

[hdl/fdd_front.sv]
// ----------------------------------------------------------------------------
// fdd_front
// input side: takes stream items, decodes the command, queues them
// ----------------------------------------------------------------------------
`default_nettype none
module fdd_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [33:0]   in_bits,
    output logic               q_valid,
    input  wire logic          q_take,
    output fdd_pkg::item_t     q_item
);
    import fdd_pkg::*;

    item_t      mem_reg [QueueDepth];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    item_t      item_in;

    // decode the packed stream word
    always_comb
    begin
        item_in.cmd           = cmd_t'(in_bits[1:0]);
        item_in.data          = in_bits[17:2];
        item_in.word_count    = in_bits[31:18];
        item_in.write_dir     = in_bits[32];
        item_in.wait_for_sync = in_bits[33];
    end

    assign in_ready = (cnt_reg != 2'(QueueDepth));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mem_reg[wp_reg] <= item_in;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready) wp_reg <= ~wp_reg;
            if (q_take) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(q_take);
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid) else $error("queue read while empty");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QueueDepth)) else $error("queue count too large");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(QueueDepth) && !q_take) |=> !in_ready)
        else $error("queue lost full state");
`endif

endmodule
`default_nettype wire

[hdl/fdd_back.sv]
// ----------------------------------------------------------------------------
// fdd_back
// execution side: shift and sync, fifo, dma, flush sequencing, result register
// ----------------------------------------------------------------------------
`default_nettype none
module fdd_back
#(
    parameter int FIFO_DEPTH     = fdd_pkg::FifoDepthDef,
    parameter int WATCHDOG_LIMIT = fdd_pkg::WatchdogLimitDef
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [15:0]   sync_word,
    input  wire logic          auto_sync,
    input  wire logic          q_valid,
    output logic               q_take,
    input  wire fdd_pkg::item_t q_item,
    output logic               out_valid,
    input  wire logic          out_ready,
    output fdd_pkg::result_t   out_res
);
    import fdd_pkg::*;

    localparam int FW = 8 * FIFO_DEPTH;
    localparam logic [17:0] WdMax = 18'h3FFFF;
    localparam logic [17:0] WdLim = 18'(WATCHDOG_LIMIT);
    localparam logic [3:0] Depth = 4'(FIFO_DEPTH);

    logic [15:0] shift_reg, shift_next;
    logic [2:0]  bcnt_reg, bcnt_next;
    logic [FW-1:0] fb_reg, fb_next;
    logic [3:0]  lvl_reg, lvl_next;
    logic [13:0] wl_reg, wl_next;
    mode_t       mode_reg, mode_next;
    logic [17:0] wd_reg, wd_next;
    logic        flush_reg, flush_next;
    logic        first_reg, first_next;
    logic        ov_reg;
    result_t     res_reg, res_next;
    logic        can_load, produce;

    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    assign can_load  = !ov_reg || out_ready;
    assign q_take    = can_load && !flush_reg && q_valid;
    assign produce   = can_load && (flush_reg || q_valid);

    // byte at level position
    function automatic logic [7:0] fbyte(input logic [FW-1:0] f, input logic [3:0] idx);
        fbyte = f[{idx[2:0], 3'b000} +: 8];
    endfunction

    // per-item step
    always_comb
    begin
        logic [7:0]  b;
        logic        seen, hit;
        logic [3:0]  l;
        shift_next = shift_reg;
        bcnt_next  = bcnt_reg;
        fb_next    = fb_reg;
        lvl_next   = lvl_reg;
        wl_next    = wl_reg;
        mode_next  = mode_reg;
        wd_next    = wd_reg;
        flush_next = flush_reg;
        first_next = first_reg;
        res_next   = '0;
        res_next.last = 1'b1;
        b    = q_item.data[7:0];
        seen = 1'b0;
        hit  = 1'b0;
        l    = 4'd0;
        if (flush_reg)
        begin
            // drain one byte per result
            l = lvl_reg - 4'd1;
            lvl_next = l;
            res_next.disk_byte_valid = 1'b1;
            res_next.disk_byte = fbyte(fb_reg, l);
            res_next.word_taken = first_reg;
            res_next.block_irq = first_reg;
            res_next.last = (l == 4'd0);
            first_next = 1'b0;
            if (l == 4'd0)
            begin
                flush_next = 1'b0;
                fb_next = '0;
            end
        end
        else
        begin
            case (q_item.cmd)
                CMD_START:
                begin
                    fb_next = '0;
                    lvl_next = 4'd0;
                    wl_next = q_item.word_count;
                    if (q_item.word_count == 14'd0) mode_next = MODE_OFF;
                    else if (q_item.write_dir) mode_next = MODE_WRITE;
                    else if (q_item.wait_for_sync) mode_next = MODE_WAIT;
                    else mode_next = MODE_READ;
                end
                CMD_DISK:
                begin
                    if (mode_reg == MODE_WRITE)
                    begin
                        if (lvl_reg != 4'd0)
                        begin
                            l = lvl_reg - 4'd1;
                            lvl_next = l;
                            res_next.disk_byte_valid = 1'b1;
                            res_next.disk_byte = fbyte(fb_reg, l);
                        end
                    end
                    else
                    begin
                        // eight dependent bit steps on narrow state
                        for (int i = 7; i >= 0; i--)
                        begin
                            shift_next = {shift_next[14:0], b[i]};
                            bcnt_next = bcnt_next + 3'd1;
                            if (bcnt_next == 3'd0)
                            begin
                                if (lvl_next >= Depth) lvl_next = Depth - 4'd2;
                                fb_next = {fb_next[FW-9:0], shift_next[7:0]};
                                lvl_next = lvl_next + 4'd1;
                            end
                            hit = (shift_next == sync_word);
                            if (!hit && auto_sync)
                            begin
                                hit = (wd_next > WdLim);
                                if (wd_next < WdMax) wd_next = wd_next + 18'd1;
                            end
                            if (hit)
                            begin
                                seen = 1'b1;
                                if (mode_next == MODE_WAIT)
                                begin
                                    bcnt_next = 3'd0;
                                    fb_next = '0;
                                    lvl_next = 4'd0;
                                    mode_next = MODE_READ;
                                end
                                wd_next = 18'd0;
                            end
                        end
                        res_next.sync_irq = seen;
                    end
                end
                CMD_DMA:
                begin
                    if (wl_reg != 14'd0 && mode_reg == MODE_READ)
                    begin
                        if (lvl_reg >= 4'd2)
                        begin
                            l = lvl_reg - 4'd2;
                            lvl_next = l;
                            res_next.mem_write_valid = 1'b1;
                            res_next.mem_word = {fbyte(fb_reg, l + 4'd1), fbyte(fb_reg, l)};
                            wl_next = wl_reg - 14'd1;
                            if (wl_next == 14'd0)
                            begin
                                res_next.block_irq = 1'b1;
                                mode_next = MODE_OFF;
                            end
                        end
                    end
                    else if (wl_reg != 14'd0 && mode_reg == MODE_WRITE)
                    begin
                        if (lvl_reg + 4'd2 <= Depth)
                        begin
                            fb_next = {fb_reg[FW-17:0], q_item.data};
                            lvl_next = lvl_reg + 4'd2;
                            wl_next = wl_reg - 14'd1;
                            res_next.word_taken = 1'b1;
                            if (wl_next == 14'd0)
                            begin
                                // start drain; first byte out now
                                mode_next = MODE_OFF;
                                l = lvl_next - 4'd1;
                                lvl_next = l;
                                res_next.disk_byte_valid = 1'b1;
                                res_next.disk_byte = fbyte(fb_next, l);
                                res_next.block_irq = 1'b1;
                                res_next.last = (l == 4'd0);
                                first_next = 1'b0;
                                if (l == 4'd0) fb_next = '0;
                                else flush_next = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        res_next.fifo_fill = lvl_next[2:0];
        res_next.dma_mode = mode_next;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (produce) res_reg <= res_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            bcnt_reg  <= '0;
            fb_reg    <= '0;
            lvl_reg   <= '0;
            wl_reg    <= '0;
            mode_reg  <= MODE_OFF;
            wd_reg    <= '0;
            flush_reg <= 1'b0;
            first_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (produce)
            begin
                shift_reg <= shift_next;
                bcnt_reg  <= bcnt_next;
                fb_reg    <= fb_next;
                lvl_reg   <= lvl_next;
                wl_reg    <= wl_next;
                mode_reg  <= mode_next;
                wd_reg    <= wd_next;
                flush_reg <= flush_next;
                first_reg <= first_next;
            end
            if (can_load) ov_reg <= produce;
        end
    end

`ifndef SYNTHESIS
    a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= Depth) else $error("fifo level beyond depth");
    a_flush_off: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (mode_reg == MODE_OFF && lvl_reg != 4'd0))
        else $error("flush in bad state");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg && $stable(res_reg))
        else $error("result changed under stall");
`endif

endmodule
`default_nettype wire
